// File: rtl/bcr_pkg.sv
// Shared types, constants and register map for the bit clock recovery DPLL.
package bcr_pkg;

    localparam int unsigned REG_W     = 12;
    localparam int unsigned ERR_W     = 13;
    localparam int unsigned PERIOD_W  = 14;
    localparam int unsigned CALC_W    = 15;
    localparam int unsigned ADDR_W    = 5;
    localparam int unsigned APB_W     = 32;
    localparam int unsigned S_DATA_W  = 8;
    localparam int unsigned M_DATA_W  = 16;

    localparam logic [REG_W-1:0] BIT_LENGTH_RST      = 12'd64;
    localparam logic [REG_W-1:0] SAMPLE_OFFSET_RST   = 12'd32;
    localparam logic [REG_W-1:0] SMALL_THRESHOLD_RST = 12'd1;
    localparam logic [REG_W-1:0] LARGE_THRESHOLD_RST = 12'd4;
    localparam logic [REG_W-1:0] LARGE_STEP_RST      = 12'd8;

    localparam logic signed [CALC_W-1:0] FINE_STEP   = 15'sd2;
    localparam logic signed [CALC_W-1:0] IDLE_BIAS   = 15'sd5;
    localparam logic signed [CALC_W-1:0] MIN_PERIOD  = 15'sd1;
    localparam logic signed [ERR_W-1:0]  DIV8_ROUND  = 13'sd7;

    typedef enum logic [2:0] {
        REG_BIT_LENGTH      = 3'd0,
        REG_SAMPLE_OFFSET   = 3'd1,
        REG_SMALL_THRESHOLD = 3'd2,
        REG_LARGE_THRESHOLD = 3'd3,
        REG_LARGE_STEP      = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [REG_W-1:0] bit_length;
        logic [REG_W-1:0] sample_offset;
        logic [REG_W-1:0] small_threshold;
        logic [REG_W-1:0] large_threshold;
        logic [REG_W-1:0] large_step;
    } t_cfg;

endpackage

// File: rtl/bcr_next_period.sv
// Loop filter: picks the next bit period from the measured phase error.
module bcr_next_period (
    input  bcr_pkg::t_cfg                      i_cfg,
    input  logic signed [bcr_pkg::ERR_W-1:0]   i_err,
    input  logic                               i_rx,
    output logic [bcr_pkg::PERIOD_W-1:0]       o_period
);

    logic                                 neg;
    logic [bcr_pkg::ERR_W-1:0]            mag_full;
    logic [bcr_pkg::REG_W-1:0]            mag;
    logic signed [bcr_pkg::ERR_W-1:0]     err_adj;
    logic signed [bcr_pkg::ERR_W-1:0]     quot;
    logic signed [bcr_pkg::CALC_W-1:0]    len;
    logic signed [bcr_pkg::CALC_W-1:0]    step;
    logic signed [bcr_pkg::CALC_W-1:0]    quot_x;
    logic signed [bcr_pkg::CALC_W-1:0]    p;

    always_comb begin
        neg      = i_err[bcr_pkg::ERR_W-1];
        mag_full = neg ? (-i_err) : i_err;
        mag      = mag_full[bcr_pkg::REG_W-1:0];
        // divide by 8 truncating toward zero: bias negatives before the shift
        err_adj  = neg ? (i_err + bcr_pkg::DIV8_ROUND) : i_err;
        quot     = err_adj >>> 3;
        quot_x   = {{(bcr_pkg::CALC_W-bcr_pkg::ERR_W){quot[bcr_pkg::ERR_W-1]}}, quot};
        len      = $signed({{(bcr_pkg::CALC_W-bcr_pkg::REG_W){1'b0}}, i_cfg.bit_length});
        step     = $signed({{(bcr_pkg::CALC_W-bcr_pkg::REG_W){1'b0}}, i_cfg.large_step});

        if (mag < i_cfg.small_threshold) begin
            p = len;
        end else if (mag < i_cfg.large_threshold) begin
            p = neg ? (len + bcr_pkg::FINE_STEP) : (len - bcr_pkg::FINE_STEP);
        end else if (i_rx) begin
            p = neg ? (len + step) : (len - step);
        end else begin
            p = len - bcr_pkg::IDLE_BIAS - quot_x;
        end

        if (p < bcr_pkg::MIN_PERIOD) begin
            p = bcr_pkg::MIN_PERIOD;
        end
        o_period = p[bcr_pkg::PERIOD_W-1:0];
    end

endmodule

// File: rtl/bit_clock_recovery_dpll_core.sv
// Bit clock recovery DPLL top level: stream ports, config registers, counters.
// Result: registered, on the master side in the cycle after the input transfer.
// Throughput: one sample per cycle unless the master side stalls; the counter update
// and the loop filter sit between the accepted sample and the single output register.
// Reset (synchronous, active low): registers return to their reset values,
// the period counter loads the reset bit length, the output register empties.
module bit_clock_recovery_dpll_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // APB config port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bcr_pkg::ADDR_W-1:0]        paddr,
    input  logic [bcr_pkg::APB_W-1:0]         pwdata,
    output logic [bcr_pkg::APB_W-1:0]         prdata,
    output logic                              pready,
    // sample stream in
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [bcr_pkg::S_DATA_W-1:0]      i_s_tdata,  // [0] sample_bit, rest zero
    input  logic                              i_s_tuser,  // [0] receiving
    // result stream out
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [bcr_pkg::M_DATA_W-1:0]      o_m_tdata   // [0] sample_echo,
                                                          // [1] strobe_res,
                                                          // [14:2] phase_error, [15] zero
);

    bcr_pkg::t_cfg                        r_cfg;
    logic [1:0]                           r_hist;
    logic [bcr_pkg::PERIOD_W-1:0]         r_period;
    logic [bcr_pkg::REG_W-1:0]            r_edge;
    logic signed [bcr_pkg::ERR_W-1:0]     r_phase;
    logic                                 r_out_valid;
    logic [bcr_pkg::M_DATA_W-1:0]         r_out_data;

    logic [1:0]                           n_hist;
    logic [bcr_pkg::PERIOD_W-1:0]         n_period;
    logic [bcr_pkg::REG_W-1:0]            n_edge;
    logic signed [bcr_pkg::ERR_W-1:0]     n_phase;
    logic                                 n_strobe;

    logic                                 s_xfer;
    logic                                 cfg_wr;
    bcr_pkg::t_reg_idx                    reg_idx;
    logic [bcr_pkg::PERIOD_W-1:0]         period_dec;
    logic [bcr_pkg::REG_W:0]              edge_inc;
    logic signed [bcr_pkg::ERR_W-1:0]     err;
    logic [bcr_pkg::PERIOD_W-1:0]         filt_period;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = bcr_pkg::t_reg_idx'(paddr[bcr_pkg::ADDR_W-1:2]);

    always_comb begin
        case (reg_idx)
            bcr_pkg::REG_BIT_LENGTH:      prdata = {20'd0, r_cfg.bit_length};
            bcr_pkg::REG_SAMPLE_OFFSET:   prdata = {20'd0, r_cfg.sample_offset};
            bcr_pkg::REG_SMALL_THRESHOLD: prdata = {20'd0, r_cfg.small_threshold};
            bcr_pkg::REG_LARGE_THRESHOLD: prdata = {20'd0, r_cfg.large_threshold};
            bcr_pkg::REG_LARGE_STEP:      prdata = {20'd0, r_cfg.large_step};
            default:                      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bit_length      <= bcr_pkg::BIT_LENGTH_RST;
            r_cfg.sample_offset   <= bcr_pkg::SAMPLE_OFFSET_RST;
            r_cfg.small_threshold <= bcr_pkg::SMALL_THRESHOLD_RST;
            r_cfg.large_threshold <= bcr_pkg::LARGE_THRESHOLD_RST;
            r_cfg.large_step      <= bcr_pkg::LARGE_STEP_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                bcr_pkg::REG_BIT_LENGTH:      r_cfg.bit_length      <= pwdata[11:0];
                bcr_pkg::REG_SAMPLE_OFFSET:   r_cfg.sample_offset   <= pwdata[11:0];
                bcr_pkg::REG_SMALL_THRESHOLD: r_cfg.small_threshold <= pwdata[11:0];
                bcr_pkg::REG_LARGE_THRESHOLD: r_cfg.large_threshold <= pwdata[11:0];
                bcr_pkg::REG_LARGE_STEP:      r_cfg.large_step      <= pwdata[11:0];
                default:                      ;
            endcase
        end
    end

    // accept while the output slot is empty or is being drained this cycle
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign s_xfer     = i_s_tvalid && o_s_tready;

    assign err = $signed({1'b0, r_edge}) - $signed({1'b0, r_cfg.sample_offset});

    bcr_next_period u_filt (
        .i_cfg    (r_cfg),
        .i_err    (err),
        .i_rx     (i_s_tuser),
        .o_period (filt_period)
    );

    always_comb begin
        n_hist     = {r_hist[0], i_s_tdata[0]};
        period_dec = r_period - 1'b1;
        edge_inc   = {1'b0, r_edge} + 1'b1;
        n_edge     = r_edge;
        n_phase    = r_phase;
        n_period   = period_dec;
        n_strobe   = 1'b0;
        if (period_dec != '0) begin
            // restart on a rising edge or when a full bit has gone by
            if (edge_inc >= {1'b0, r_cfg.bit_length} || n_hist == 2'b01) begin
                n_edge = '0;
            end else begin
                n_edge = edge_inc[bcr_pkg::REG_W-1:0];
            end
        end else begin
            n_phase  = err;
            n_period = filt_period;
            n_strobe = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist      <= '0;
            r_period    <= {2'b00, bcr_pkg::BIT_LENGTH_RST};
            r_edge      <= '0;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_xfer) begin
                r_hist      <= n_hist;
                r_period    <= n_period;
                r_edge      <= n_edge;
                r_phase     <= n_phase;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_xfer) begin
            r_out_data <= {1'b0, n_phase, n_strobe, i_s_tdata[0]};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

`ifndef SYNTHESIS
    // a reloaded period is never zero
    a_reload_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_xfer && r_period == 14'd1) |=> (r_period != '0))
        else $error("period reloaded with zero");

    a_strobe_on_expiry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_xfer && r_period == 14'd1) |=> (o_m_tvalid && o_m_tdata[1]))
        else $error("missing strobe on period expiry");

    a_no_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_xfer && r_period != 14'd1) |=> (!o_m_tdata[1] && $stable(r_phase)))
        else $error("strobe or phase update without expiry");

    a_edge_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_xfer && r_period == 14'd1) |=> $stable(r_edge))
        else $error("edge counter moved on strobe");

    a_idle_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_m_tvalid)
        else $error("output valid right after reset");
`endif

endmodule

// File: bench/tb_bit_clock_recovery_dpll_core.sv
`timescale 1ns / 100ps
// Self-checking bench for the bit clock recovery DPLL core: stream traffic, APB setup, predictor.
module tb_bit_clock_recovery_dpll_core;

    localparam int          CYCLE_LIMIT      = 400000;
    localparam int unsigned REG_COUNT        = 5;
    localparam int unsigned REG_UNMAPPED_LO  = 5;
    localparam int unsigned REG_UNMAPPED_HI  = 7;
    localparam int          FINE_STEP_SMP    = 2;
    localparam int          IDLE_BIAS_SMP    = 5;
    localparam int          IDLE_ERR_DIV     = 8;
    localparam int          SHORTEST_PERIOD  = 1;
    localparam int          RX_OFF           = 0;
    localparam int          RX_ON            = 1;
    localparam int          RX_MIXED         = 2;

    typedef struct packed {
        logic                             echo;
        logic                             strobe;
        logic signed [bcr_pkg::ERR_W-1:0] phase_err;
    } t_sync_result;

    logic                         i_clk      = 1'b0;
    logic                         i_rst_n    = 1'b0;
    logic                         psel       = 1'b0;
    logic                         penable    = 1'b0;
    logic                         pwrite     = 1'b0;
    logic [bcr_pkg::ADDR_W-1:0]   paddr      = '0;
    logic [bcr_pkg::APB_W-1:0]    pwdata     = '0;
    logic [bcr_pkg::APB_W-1:0]    prdata;
    logic                         pready;
    logic                         i_s_tvalid = 1'b0;
    logic                         o_s_tready;
    logic [bcr_pkg::S_DATA_W-1:0] i_s_tdata  = '0;  // [0] sample_bit, [7:1] zero
    logic                         i_s_tuser  = 1'b0; // [0] receiving
    logic                         o_m_tvalid;
    logic                         i_m_tready = 1'b0;
    logic [bcr_pkg::M_DATA_W-1:0] o_m_tdata;         // [0] sample_echo, [1] strobe_res,
                                                     // [14:2] phase_error, [15] zero

    // register copies and loop state as the block should hold them
    logic [bcr_pkg::REG_W-1:0]        cfg_regs [REG_COUNT];
    logic [1:0]                       trk_hist;
    logic [bcr_pkg::PERIOD_W-1:0]     trk_period;
    logic [bcr_pkg::REG_W-1:0]        trk_edge_cnt;
    logic signed [bcr_pkg::ERR_W-1:0] trk_err;

    t_sync_result sync_results_q [$];

    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int error_cnt     = 0;
    int cycle_cnt     = 0;
    int samples_sent  = 0;
    int strobes_seen  = 0;
    int cfg_sets      = 0;

    bit_clock_recovery_dpll_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t ns: run stuck, %0d results still outstanding",
                     $time, sync_results_q.size());
            $display("** bit_clock_recovery_dpll_core: FAILED **");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_m_tready <= (int'($urandom_range(99)) >= snk_stall_pct);
    end

    function automatic t_sync_result dpll_track_sample(input logic smp, input logic rx);
        t_sync_result res;
        int           cnt_next;
        int           err;
        int           mag;
        int           len;
        int           nxt;
        len        = int'(cfg_regs[bcr_pkg::REG_BIT_LENGTH]);
        trk_hist   = {trk_hist[0], smp};
        trk_period = trk_period - 1'b1;
        if (trk_period != '0) begin
            cnt_next = int'(trk_edge_cnt) + 1;
            // wrap at the bit length, restart on a rising edge
            if (cnt_next >= len || trk_hist == 2'b01)
                cnt_next = 0;
            trk_edge_cnt = cnt_next[bcr_pkg::REG_W-1:0];
            res.strobe   = 1'b0;
        end else begin
            err     = int'(trk_edge_cnt) - int'(cfg_regs[bcr_pkg::REG_SAMPLE_OFFSET]);
            trk_err = err[bcr_pkg::ERR_W-1:0];
            mag     = (err < 0) ? -err : err;
            if (mag < int'(cfg_regs[bcr_pkg::REG_SMALL_THRESHOLD]))
                nxt = len;
            else if (mag < int'(cfg_regs[bcr_pkg::REG_LARGE_THRESHOLD]))
                nxt = (err < 0) ? len + FINE_STEP_SMP : len - FINE_STEP_SMP;
            else if (rx)
                nxt = (err < 0) ? len + int'(cfg_regs[bcr_pkg::REG_LARGE_STEP])
                                : len - int'(cfg_regs[bcr_pkg::REG_LARGE_STEP]);
            else
                nxt = len - IDLE_BIAS_SMP - err / IDLE_ERR_DIV;
            if (nxt < SHORTEST_PERIOD)
                nxt = SHORTEST_PERIOD;
            trk_period = nxt[bcr_pkg::PERIOD_W-1:0];
            res.strobe = 1'b1;
        end
        res.echo      = smp;
        res.phase_err = trk_err;
        return res;
    endfunction

    // predict on every sample transfer
    always @(posedge i_clk) begin : sample_monitor
        t_sync_result res;
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            res = dpll_track_sample(i_s_tdata[0], i_s_tuser);
            sync_results_q.push_back(res);
            samples_sent <= samples_sent + 1;
        end
    end

    always @(posedge i_clk) begin : result_checker
        t_sync_result want;
        t_sync_result got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.echo      = o_m_tdata[0];
            got.strobe    = o_m_tdata[1];
            got.phase_err = $signed(o_m_tdata[bcr_pkg::ERR_W+1:2]);
            if (got.strobe)
                strobes_seen <= strobes_seen + 1;
            if (sync_results_q.size() == 0) begin
                error_cnt <= error_cnt + 1;
                $display("%0t ns: unexpected result: expected none, %s%0b %s%0b %s%0d",
                         $time, "actual echo=", got.echo, "strobe=", got.strobe,
                         "err=", got.phase_err);
            end else begin
                want = sync_results_q.pop_front();
                if (got.echo !== want.echo || got.strobe !== want.strobe ||
                    got.phase_err !== want.phase_err) begin
                    error_cnt <= error_cnt + 1;
                    $display("%0t ns: result mismatch: expected echo=%0b strobe=%0b err=%0d,",
                             $time, want.echo, want.strobe, want.phase_err);
                    $display("%0t ns:   actual echo=%0b strobe=%0b err=%0d",
                             $time, got.echo, got.strobe, got.phase_err);
                end
            end
        end
    end

    task automatic apply_reset();
        cfg_regs[bcr_pkg::REG_BIT_LENGTH]      = bcr_pkg::BIT_LENGTH_RST;
        cfg_regs[bcr_pkg::REG_SAMPLE_OFFSET]   = bcr_pkg::SAMPLE_OFFSET_RST;
        cfg_regs[bcr_pkg::REG_SMALL_THRESHOLD] = bcr_pkg::SMALL_THRESHOLD_RST;
        cfg_regs[bcr_pkg::REG_LARGE_THRESHOLD] = bcr_pkg::LARGE_THRESHOLD_RST;
        cfg_regs[bcr_pkg::REG_LARGE_STEP]      = bcr_pkg::LARGE_STEP_RST;
        trk_hist     = '0;
        trk_period   = bcr_pkg::PERIOD_W'(bcr_pkg::BIT_LENGTH_RST);
        trk_edge_cnt = '0;
        trk_err      = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
    endtask

    task automatic set_traffic(input int idle_pct, input int stall_pct);
        src_idle_pct  = idle_pct;
        snk_stall_pct = stall_pct;
    endtask

    task automatic apb_write(input int unsigned idx, input logic [bcr_pkg::APB_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= bcr_pkg::ADDR_W'(idx << 2);
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (idx < REG_COUNT)
            cfg_regs[idx] = data[bcr_pkg::REG_W-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apb_read(input int unsigned idx, output logic [bcr_pkg::APB_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= bcr_pkg::ADDR_W'(idx << 2);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        data    = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_readback();
        logic [bcr_pkg::APB_W-1:0] rd;
        for (int unsigned i = 0; i < REG_COUNT; i++) begin
            apb_read(i, rd);
            if (rd !== bcr_pkg::APB_W'(cfg_regs[i])) begin
                error_cnt++;
                $display("%0t ns: register %0d readback: expected 0x%03h, actual 0x%08h",
                         $time, i, cfg_regs[i], rd);
            end
        end
    endtask

    // registers change only here, with the pipe empty
    task automatic program_dpll(input int bl, input int off, input int sm, input int lg,
                                input int st);
        logic [bcr_pkg::REG_W-1:0] vals [REG_COUNT];
        logic [bcr_pkg::APB_W-1:0] wd;
        vals[bcr_pkg::REG_BIT_LENGTH]      = bl[bcr_pkg::REG_W-1:0];
        vals[bcr_pkg::REG_SAMPLE_OFFSET]   = off[bcr_pkg::REG_W-1:0];
        vals[bcr_pkg::REG_SMALL_THRESHOLD] = sm[bcr_pkg::REG_W-1:0];
        vals[bcr_pkg::REG_LARGE_THRESHOLD] = lg[bcr_pkg::REG_W-1:0];
        vals[bcr_pkg::REG_LARGE_STEP]      = st[bcr_pkg::REG_W-1:0];
        for (int unsigned i = 0; i < REG_COUNT; i++) begin
            wd                     = $urandom();
            wd[bcr_pkg::REG_W-1:0] = vals[i];
            apb_write(i, wd);
        end
        // writes past the map must not land anywhere
        apb_write($urandom_range(REG_UNMAPPED_HI, REG_UNMAPPED_LO), $urandom());
        check_readback();
        cfg_sets++;
    endtask

    task automatic send_sample(input logic smp, input logic rx);
        while (int'($urandom_range(99)) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{(bcr_pkg::S_DATA_W-1){1'b0}}, smp};
        i_s_tuser  <= rx;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic finish_phase();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sync_results_q.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // bit runs near the nominal length with jitter, plus short noise bursts
    task automatic send_bit_stream(input int n_items, input int run_len, input int rx_mode);
        int   sent;
        int   len;
        int   jit;
        logic lvl;
        logic rx;
        sent = 0;
        lvl  = 1'($urandom_range(1));
        rx   = (rx_mode == RX_MIXED) ? logic'($urandom_range(1)) : (rx_mode == RX_ON);
        while (sent < n_items) begin
            if ($urandom_range(9) == 0) begin
                len = $urandom_range(5, 1);
                for (int k = 0; k < len && sent < n_items; k++) begin
                    send_sample(1'($urandom_range(1)), rx);
                    sent++;
                end
            end else begin
                jit = run_len / 8 + 1;
                len = run_len + int'($urandom_range(2 * jit)) - jit;
                if (len < 1)
                    len = 1;
                if ($urandom_range(3) != 0)
                    lvl = !lvl;
                for (int k = 0; k < len && sent < n_items; k++) begin
                    send_sample(lvl, rx);
                    sent++;
                end
            end
            if (rx_mode == RX_MIXED && $urandom_range(29) == 0)
                rx = !rx;
        end
    endtask

    task automatic test_reset_defaults();
        check_readback();
        // one rising edge, then hold high through the first expiry
        for (int i = 0; i < 70; i++)
            send_sample(i >= 20, 1'b1);
        finish_phase();
    endtask

    task automatic test_fine_and_coarse();
        program_dpll(8, 4, 1, 3, 2);
        send_bit_stream(40, 8, RX_ON);
        send_bit_stream(40, 8, RX_OFF);
        finish_phase();
    endtask

    task automatic test_swapped_thresholds();
        program_dpll(6, 3, 5, 2, 3);
        send_bit_stream(40, 6, RX_MIXED);
        finish_phase();
    endtask

    task automatic test_period_clamp();
        // every error is coarse and the correction overshoots below one
        program_dpll(4, 0, 0, 0, 4095);
        send_bit_stream(20, 4, RX_ON);
        send_bit_stream(20, 4, RX_OFF);
        finish_phase();
    endtask

    task automatic test_zero_bit_length();
        program_dpll(0, 0, 1, 2, 0);
        send_bit_stream(20, 4, RX_MIXED);
        finish_phase();
        program_dpll(0, 9, 1, 2, 3);
        send_bit_stream(20, 4, RX_MIXED);
        finish_phase();
    endtask

    task automatic test_random_traffic();
        int idle_tab  [4] = '{0, 47, 0, 16};
        int stall_tab [4] = '{0, 0, 47, 16};
        int bl;
        int off;
        int sm;
        int lg;
        int st;
        int tmp;
        for (int ph = 0; ph < 4; ph++) begin
            set_traffic(idle_tab[ph], stall_tab[ph]);
            for (int sub = 0; sub < 2; sub++) begin
                if ($urandom_range(9) == 0)
                    bl = $urandom_range(3);
                else if ($urandom_range(9) == 0)
                    bl = $urandom_range(200, 33);
                else
                    bl = $urandom_range(32, 4);
                off = $urandom_range(bl + bl / 2);
                sm  = $urandom_range(bl / 4 + 1);
                lg  = sm + int'($urandom_range(bl / 4 + 2));
                if ($urandom_range(5) == 0) begin
                    tmp = sm;
                    sm  = lg;
                    lg  = tmp;
                end
                st = $urandom_range(bl);
                program_dpll(bl, off, sm, lg, st);
                send_bit_stream(44, (bl < 1) ? 4 : bl, RX_MIXED);
                finish_phase();
            end
        end
        set_traffic(0, 0);
    endtask

    task automatic test_extremes();
        set_traffic(16, 16);
        // most negative error, coarse step of zero while receiving
        program_dpll(16, 4095, 0, 4095, 0);
        send_bit_stream(30, 16, RX_ON);
        finish_phase();
        program_dpll(4095, 0, 4095, 4095, 4095);
        send_bit_stream(40, 4095, RX_MIXED);
        finish_phase();
        // idle loop filter with the largest error magnitude
        program_dpll(16, 4095, 0, 4095, 0);
        send_bit_stream(20, 16, RX_OFF);
        finish_phase();
        set_traffic(0, 0);
    endtask

    initial begin
        apply_reset();
        set_traffic(0, 0);
        test_reset_defaults();
        test_fine_and_coarse();
        test_swapped_thresholds();
        test_period_clamp();
        test_zero_bit_length();
        test_random_traffic();
        test_extremes();
        finish_phase();
        repeat (4) @(posedge i_clk);
        $display("Covered %0d sample transfers, %0d sync strobes, %0d register settings,",
                 samples_sent, strobes_seen, cfg_sets);
        $display("idle mixes none / sender 47%% / receiver 47%% / both 16%%; %0d mismatches.",
                 error_cnt);
        if (error_cnt == 0)
            $display("** bit_clock_recovery_dpll_core: PASSED **");
        else
            $display("** bit_clock_recovery_dpll_core: FAILED **");
        $finish;
    end

endmodule
